@@ hdl/udlf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// udlf_pkg
// Shared types, constants and character helpers for the URL decode /
// lower-case filter.
// ---------------------------------------------------------------------------
package udlf_pkg;

  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // result queue depth
  localparam int unsigned RQ_DEPTH = 2;
  localparam int unsigned RQ_PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // escape sequencer
  typedef enum logic [2:0] {
    ESC_TEXT = 3'b001,
    ESC_DIG1 = 3'b010,
    ESC_DIG2 = 3'b100
  } esc_state_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       kept;
    logic       last;
    logic       empty;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.val = 4'(b - 8'h30);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.val = 4'(b - 8'h41 + 8'd10);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.val = 4'(b - 8'h61 + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // ASCII capitals and the acute-accented ISO-8859-15 capitals A E I O U plus N-tilde
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'd65:8'd90], 8'd193, 8'd201, 8'd205, 8'd211, 8'd218, 8'd209}) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_kept(input logic [7:0] c);
    return c inside {[8'd97:8'd122], [8'd48:8'd57], CH_SPACE,
                     8'd225, 8'd233, 8'd237, 8'd243, 8'd250, 8'd241};
  endfunction

endpackage : udlf_pkg
`default_nettype wire

@@ hdl/udlf_decode.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// udlf_decode
// Per-byte percent decoding, case folding and character filter, with the
// escape sequencer and the per-message kept flag.
// ---------------------------------------------------------------------------
module udlf_decode
  import udlf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output res_t            res,
  output logic            res_push
);

  esc_state_t esc_r, esc_nxt;
  logic [3:0] esc_val_r, esc_val_nxt;
  logic       dig_ok_r, dig_ok_nxt;
  logic       kept_any_r, kept_any_nxt;

  hex_t       hx;
  logic       have;
  logic [7:0] dec;
  logic [7:0] folded;
  logic       keep;

  always_comb begin
    hx          = hex_digit(in_byte);
    have        = 1'b0;
    dec         = 8'd0;
    esc_nxt     = esc_r;
    esc_val_nxt = esc_val_r;
    dig_ok_nxt  = dig_ok_r;
    case (esc_r)
      ESC_DIG1: begin
        dig_ok_nxt  = hx.ok;
        esc_val_nxt = hx.val;
        esc_nxt     = ESC_DIG2;
      end
      ESC_DIG2: begin
        // bad second digit: first digit stands alone
        have    = dig_ok_r;
        dec     = hx.ok ? {esc_val_r, hx.val} : {4'd0, esc_val_r};
        esc_nxt = ESC_TEXT;
      end
      default: begin
        esc_nxt = ESC_TEXT;
        if (in_byte == CH_PERCENT) begin
          esc_nxt = ESC_DIG1;
        end else begin
          have = 1'b1;
          dec  = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
        end
      end
    endcase

    folded       = fold_lower(dec);
    keep         = have && is_kept(folded);
    kept_any_nxt = kept_any_r | keep;

    res.chr   = keep ? folded : 8'd0;
    res.kept  = keep;
    res.last  = in_last;
    res.empty = in_last && !kept_any_nxt;
    res_push  = fire && (keep || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r      <= ESC_TEXT;
      esc_val_r  <= 4'd0;
      dig_ok_r   <= 1'b0;
      kept_any_r <= 1'b0;
    end else if (fire) begin
      if (in_last) begin
        esc_r      <= ESC_TEXT;
        esc_val_r  <= 4'd0;
        dig_ok_r   <= 1'b0;
        kept_any_r <= 1'b0;
      end else begin
        esc_r      <= esc_nxt;
        esc_val_r  <= esc_val_nxt;
        dig_ok_r   <= dig_ok_nxt;
        kept_any_r <= kept_any_nxt;
      end
    end
  end

endmodule : udlf_decode
`default_nettype wire

@@ hdl/udlf_res_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// udlf_res_queue
// Small result queue; registered output, decouples the consumer's ready
// from the input side.
// ---------------------------------------------------------------------------
module udlf_res_queue
  import udlf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  res_t      push_data,
  output logic      space,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output res_t      pop_data
);

  res_t                mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign space     = (cnt_r != RQ_CNT_W'(RQ_DEPTH));
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule : udlf_res_queue
`default_nettype wire

@@ hdl/url_decode_lowercase_filter.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// url_decode_lowercase_filter
// Streaming form-value URL decoder with lower-case character filter.
// ---------------------------------------------------------------------------
// Takes one encoded byte per clock while in_ready is high, decodes it in the
// same cycle ('+' to space, '%XX' to a byte), folds capitals to lower case
// and keeps only a-z, 0-9, space and the accented lower-case letters. Each
// request gives at most one result, a kept character or the closing result
// of a message (in_last), which carries out_empty when nothing was kept. A
// result is written into the result queue and reaches the output from there;
// the per-byte decode logic sets the rate of one request per clock. Results
// sit in a two-entry queue, so in_ready drops only when two wait to be taken.
module url_decode_lowercase_filter
  import udlf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_res_valid,
  input  wire logic       out_res_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_last,
  output logic            out_empty
);

  logic fire;
  logic push;
  res_t push_res;
  res_t head;

  assign fire = in_valid && in_ready;

  udlf_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .res      (push_res),
    .res_push (push)
  );

  udlf_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_res),
    .space     (in_ready),
    .pop_valid (out_res_valid),
    .pop_ready (out_res_ready),
    .pop_data  (head)
  );

  assign out_byte  = head.chr;
  assign out_valid = head.kept;
  assign out_last  = head.last;
  assign out_empty = head.empty;

  // closing request always yields a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> out_res_valid)
    else $error("closing request produced no result");

  a_empty_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res_valid && out_empty) |-> (out_last && !out_valid))
    else $error("empty flag outside a closing result");

  a_dropped_is_closing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res_valid && !out_valid) |-> (out_last && out_byte == 8'd0))
    else $error("result without character that is not closing");

  a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_res_valid)
    else $error("input stalled with no result pending");

endmodule : url_decode_lowercase_filter
`default_nettype wire
